// ----- design/triangle_tangent_frame_core_defines.svh -----
// Assertion macros for the triangle tangent frame core.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TRIANGLE_TANGENT_FRAME_CORE_DEFINES_SVH
`define TRIANGLE_TANGENT_FRAME_CORE_DEFINES_SVH

// Clocked check, masked while reset is high
`define TFT_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Clocked check that also holds across reset
`define TFT_ASSERT_NORST(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ----- design/tft_pkg.sv -----
// Shared types and constants for the triangle tangent frame core.
// No dependencies; imported by every module of the block.
package tft_pkg;

  localparam int FW = 32;   // input field width
  localparam int DW = 33;   // raw edge / texture delta width
  localparam int SW = 31;   // block-scaled delta width
  localparam int UW = 16;   // Q1.14 unit component width
  localparam int VW = 64;   // product / cross vector width

  localparam logic [UW-1:0] ONE_Q14 = 16'd16384;

  typedef struct packed {
    logic [5:0][DW-1:0] e;  // e1 x,y,z then e2 x,y,z
    logic [3:0][DW-1:0] d;  // du1, du2, dv1, dv2
  } tri_t;

  typedef enum logic [2:0] {
    B_IDLE, B_SHRINK, B_MUL, B_SIGN, B_UNIT, B_OUT
  } back_state_t;

  typedef enum logic [2:0] {
    U_IDLE, U_NORM, U_SQ, U_SQRT, U_DIV
  } unit_state_t;

  typedef struct packed {
    logic done;
    logic ok;
  } unit_status_t;

endpackage

// ----- design/tft_front.sv -----
// Vertex front end: gathers three vertices and forms edges and texture deltas.
// Depends on tft_pkg.
module tft_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [159:0]  s_tdata,
  output logic          push,
  output tft_pkg::tri_t push_data,
  input  logic          full
);
  import tft_pkg::*;

  localparam int CW = (COORD_WIDTH > FW) ? FW : COORD_WIDTH;
  localparam int SH = FW - CW;

  logic [1:0]          phase;
  logic signed [FW-1:0] cur [5];
  logic signed [FW-1:0] p1  [5];
  logic signed [FW-1:0] p2  [5];
  logic [FW-1:0]        raw [5];
  logic                 acc;

  // keep the low CW bits, sign-extended
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      raw[i] = s_tdata[FW*i +: FW] << SH;
      cur[i] = $signed(raw[i]) >>> SH;
    end
  end

  assign s_tready = (phase != 2'd2) || !full;
  assign acc      = s_tvalid && s_tready;
  assign push     = acc && (phase == 2'd2);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      push_data.e[i]   = DW'(p2[i])  - DW'(p1[i]);
      push_data.e[3+i] = DW'(cur[i]) - DW'(p1[i]);
    end
    push_data.d[0] = DW'(p2[3])  - DW'(p1[3]);
    push_data.d[1] = DW'(cur[3]) - DW'(p1[3]);
    push_data.d[2] = DW'(p2[4])  - DW'(p1[4]);
    push_data.d[3] = DW'(cur[4]) - DW'(p1[4]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
    end else if (acc) begin
      case (phase)
        2'd1: begin
          p2    <= cur;
          phase <= 2'd2;
        end
        2'd2: begin
          phase <= 2'd0;
        end
        default: begin
          p1    <= cur;
          phase <= 2'd1;
        end
      endcase
    end
  end

endmodule

// ----- design/tft_fifo.sv -----
// Two-entry triangle queue between the front end and the back end.
// Depends on tft_pkg.
module tft_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tft_pkg::tri_t push_data,
  output logic          full,
  input  logic          pop,
  output tft_pkg::tri_t pop_data,
  output logic          empty
);
  import tft_pkg::*;

  tri_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && !empty) rd_ptr <= ~rd_ptr;
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

// ----- design/tft_unit.sv -----
// Iterative vector normaliser: block shift, sum of squares, bit-serial square
// root and a restoring divider per component. Depends on tft_pkg.
module tft_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [2:0][63:0]     v,
  output tft_pkg::unit_status_t status,
  output logic [2:0][15:0]     u
);
  import tft_pkg::*;

  unit_state_t state, state_next;

  logic        sgn  [3];
  logic [62:0] mag  [3];
  logic [62:0] mmax;
  logic [62:0] mag_in [3];
  logic [62:0] max_in;
  logic [59:0] prod;
  logic [61:0] sum;
  logic [61:0] n;
  logic [63:0] r;
  logic [4:0]  cnt;
  logic [1:0]  c;
  logic [31:0] rem;
  logic [15:0] numlow;
  logic [15:0] q;
  logic        done;
  logic        ok;

  logic [63:0] bitv;
  logic [63:0] trial_sq;
  logic [45:0] num;
  logic [31:0] dvs;
  logic [32:0] trial_div;
  logic        qbit;
  logic [15:0] qn;
  logic [15:0] qs;

  assign status.done = done;
  assign status.ok   = ok;

  always_comb begin
    max_in = '0;
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = v[i][63] ? 63'(-$signed(v[i])) : v[i][62:0];
      if (mag_in[i] > max_in) max_in = mag_in[i];
    end
    bitv      = 64'd1 << {cnt, 1'b0};
    trial_sq  = r + bitv;
    num       = {1'b0, mag[c][29:0], 15'd0} + 46'(r[31:0]);
    dvs       = {r[30:0], 1'b0};
    trial_div = {rem, numlow[15]};
    qbit      = (trial_div >= {1'b0, dvs});
    qn        = {q[14:0], qbit};
    qs        = (qn > ONE_Q14) ? ONE_Q14 : qn;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= U_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      U_IDLE: if (start && (max_in != '0)) state_next = U_NORM;
      U_NORM: if (mmax[62:30] == '0 && mmax[29]) state_next = U_SQ;
      U_SQ:   if (cnt == 5'd3) state_next = U_SQRT;
      U_SQRT: if (cnt == 5'd0) state_next = U_DIV;
      U_DIV:  if (cnt == 5'd16 && c == 2'd2) state_next = U_IDLE;
      default: state_next = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == U_IDLE && start && max_in == '0) ||
              (state == U_DIV && cnt == 5'd16 && c == 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      U_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            sgn[i] <= v[i][63];
            mag[i] <= mag_in[i];
          end
          mmax <= max_in;
          ok   <= (max_in != '0);
        end
      end
      U_NORM: begin
        // bring the largest magnitude into [2^29, 2^30), four bits a step when far off
        if (mmax[62:33] != '0) begin
          mmax <= mmax >> 4;
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 4;
        end else if (mmax[62:30] != '0) begin
          mmax <= mmax >> 1;
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        end else if (mmax[62:25] == '0) begin
          mmax <= mmax << 4;
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 4;
        end else if (mmax[62:29] == '0) begin
          mmax <= mmax << 1;
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
        end else begin
          cnt <= 5'd0;
          sum <= '0;
        end
      end
      U_SQ: begin
        if (cnt != 5'd3) prod <= mag[cnt[1:0]][29:0] * mag[cnt[1:0]][29:0];
        if (cnt != 5'd0) sum <= sum + 62'(prod);
        if (cnt == 5'd3) begin
          n   <= sum + 62'(prod);
          r   <= '0;
          cnt <= 5'd31;
        end else begin
          cnt <= cnt + 5'd1;
        end
      end
      U_SQRT: begin
        if ({2'b00, n} >= trial_sq) begin
          n <= n - trial_sq[61:0];
          r <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        // hold the counter at zero so the divider loads on its first cycle
        if (cnt == 5'd0) begin
          c <= 2'd0;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
      U_DIV: begin
        if (cnt == 5'd0) begin
          rem    <= 32'(num[45:16]);
          numlow <= num[15:0];
          q      <= '0;
          cnt    <= 5'd1;
        end else begin
          rem    <= qbit ? 32'(trial_div - {1'b0, dvs}) : trial_div[31:0];
          numlow <= numlow << 1;
          q      <= qn;
          if (cnt == 5'd16) begin
            u[c] <= sgn[c] ? 16'(-$signed({1'b0, qs})) : qs;
            c    <= c + 2'd1;
            cnt  <= 5'd0;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- design/tft_back.sv -----
// Back end: block scaling, shared multiplier sequencer for determinant,
// tangent, binormal and normal, normaliser calls and the output register.
// Depends on tft_pkg, tft_unit and triangle_tangent_frame_core_defines.svh.
`include "triangle_tangent_frame_core_defines.svh"
module tft_back (
  input  logic          clk,
  input  logic          rst,
  input  tft_pkg::tri_t pop_data,
  input  logic          empty,
  output logic          pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [143:0]  m_tdata,   // tangent x,y,z, binormal x,y,z, normal x,y,z (16 each)
  output logic          m_tuser    // degenerate
);
  import tft_pkg::*;

  back_state_t state, state_next;

  logic signed [DW-1:0] er [6];
  logic signed [DW-1:0] dr [4];
  logic signed [SW-1:0] es [6];
  logic signed [SW-1:0] ds [4];
  logic signed [SW-1:0] es_next [6];
  logic signed [SW-1:0] ds_next [4];
  logic [DW-1:0]        em [6];
  logic [DW-1:0]        dm [4];
  logic [1:0]           esh;
  logic [1:0]           dsh;
  logic [DW-1:0]        eor;
  logic [DW-1:0]        dor;

  logic [3:0]           pair;
  logic [1:0]           mcyc;
  logic signed [31:0]   fa, fb, sa, sb, ma, mb;
  logic signed [VW-1:0] prod;
  logic signed [VW-1:0] acc;
  logic signed [VW-1:0] det;
  logic [2:0][VW-1:0]   vec [3];
  logic [1:0]           vsel;
  logic                 ustart;
  logic                 deg;
  logic signed [UW-1:0] tu [3];
  logic signed [UW-1:0] bu [3];
  logic signed [UW-1:0] nu [3];
  logic                 load_out;

  unit_status_t         ustat;
  logic [2:0][15:0]     uvec;

  tft_unit u_unit (
    .clk    (clk),
    .rst    (rst),
    .start  (ustart),
    .v      (vec[vsel]),
    .status (ustat),
    .u      (uvec)
  );

  // shared right shift per group, magnitudes truncated toward zero
  always_comb begin
    eor = '0;
    dor = '0;
    for (int i = 0; i < 6; i++) begin
      em[i] = er[i][DW-1] ? DW'(-er[i]) : DW'(er[i]);
      eor   = eor | em[i];
    end
    for (int i = 0; i < 4; i++) begin
      dm[i] = dr[i][DW-1] ? DW'(-dr[i]) : DW'(dr[i]);
      dor   = dor | dm[i];
    end
    esh = eor[31] ? 2'd2 : (eor[30] ? 2'd1 : 2'd0);
    dsh = dor[31] ? 2'd2 : (dor[30] ? 2'd1 : 2'd0);
    for (int i = 0; i < 6; i++) begin
      es_next[i] = er[i][DW-1] ? -$signed({1'b0, 30'(em[i] >> esh)})
                               :  $signed({1'b0, 30'(em[i] >> esh)});
    end
    for (int i = 0; i < 4; i++) begin
      ds_next[i] = dr[i][DW-1] ? -$signed({1'b0, 30'(dm[i] >> dsh)})
                               :  $signed({1'b0, 30'(dm[i] >> dsh)});
    end
  end

  // operand pairs: result = fa*fb - sa*sb
  always_comb begin
    fa = '0; fb = '0; sa = '0; sb = '0;
    case (pair)
      4'd0: begin fa = 32'(ds[0]); fb = 32'(ds[3]); sa = 32'(ds[1]); sb = 32'(ds[2]); end
      4'd1: begin fa = 32'(ds[3]); fb = 32'(es[0]); sa = 32'(ds[2]); sb = 32'(es[3]); end
      4'd2: begin fa = 32'(ds[3]); fb = 32'(es[1]); sa = 32'(ds[2]); sb = 32'(es[4]); end
      4'd3: begin fa = 32'(ds[3]); fb = 32'(es[2]); sa = 32'(ds[2]); sb = 32'(es[5]); end
      4'd4: begin fa = 32'(ds[0]); fb = 32'(es[3]); sa = 32'(ds[1]); sb = 32'(es[0]); end
      4'd5: begin fa = 32'(ds[0]); fb = 32'(es[4]); sa = 32'(ds[1]); sb = 32'(es[1]); end
      4'd6: begin fa = 32'(ds[0]); fb = 32'(es[5]); sa = 32'(ds[1]); sb = 32'(es[2]); end
      4'd7: begin fa = 32'(tu[1]); fb = 32'(bu[2]); sa = 32'(tu[2]); sb = 32'(bu[1]); end
      4'd8: begin fa = 32'(tu[2]); fb = 32'(bu[0]); sa = 32'(tu[0]); sb = 32'(bu[2]); end
      4'd9: begin fa = 32'(tu[0]); fb = 32'(bu[1]); sa = 32'(tu[1]); sb = 32'(bu[0]); end
      default: ;
    endcase
    ma = (mcyc == 2'd0) ? fa : sa;
    mb = (mcyc == 2'd0) ? fb : sb;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    case (state)
      B_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = B_SHRINK;
        end
      end
      B_SHRINK: state_next = B_MUL;
      B_MUL: begin
        if (mcyc == 2'd2 && pair == 4'd6) state_next = B_SIGN;
        if (mcyc == 2'd2 && pair == 4'd9) state_next = B_UNIT;
      end
      B_SIGN: state_next = (det == '0) ? B_OUT : B_UNIT;
      B_UNIT: begin
        if (ustat.done) begin
          if (!ustat.ok || vsel == 2'd2) state_next = B_OUT;
          else if (vsel == 2'd1)         state_next = B_MUL;
        end
      end
      B_OUT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ustart   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      ustart <= ((state == B_SIGN) && (det != '0)) ||
                ((state == B_MUL) && (mcyc == 2'd2) && (pair == 4'd9)) ||
                ((state == B_UNIT) && ustat.done && ustat.ok && (vsel == 2'd0));
      if (load_out)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!empty) begin
          for (int i = 0; i < 6; i++) er[i] <= $signed(pop_data.e[i]);
          for (int i = 0; i < 4; i++) dr[i] <= $signed(pop_data.d[i]);
        end
      end
      B_SHRINK: begin
        es   <= es_next;
        ds   <= ds_next;
        pair <= 4'd0;
        mcyc <= 2'd0;
        deg  <= 1'b0;
      end
      B_MUL: begin
        case (mcyc)
          2'd0: begin
            prod <= ma * mb;
            mcyc <= 2'd1;
          end
          2'd1: begin
            acc  <= prod;
            prod <= ma * mb;
            mcyc <= 2'd2;
          end
          default: begin
            case (pair)
              4'd0: det       <= acc - prod;
              4'd1: vec[0][0] <= acc - prod;
              4'd2: vec[0][1] <= acc - prod;
              4'd3: vec[0][2] <= acc - prod;
              4'd4: vec[1][0] <= acc - prod;
              4'd5: vec[1][1] <= acc - prod;
              4'd6: vec[1][2] <= acc - prod;
              4'd7: vec[2][0] <= acc - prod;
              4'd8: vec[2][1] <= acc - prod;
              4'd9: vec[2][2] <= acc - prod;
              default: ;
            endcase
            mcyc <= 2'd0;
            pair <= pair + 4'd1;
            if (pair == 4'd9) vsel <= 2'd2;
          end
        endcase
      end
      B_SIGN: begin
        if (det == '0) begin
          deg <= 1'b1;
        end else begin
          vsel <= 2'd0;
          // flip both vectors when the texture determinant is negative
          if (det < 0) begin
            for (int k = 0; k < 2; k++) begin
              for (int i = 0; i < 3; i++) vec[k][i] <= -$signed(vec[k][i]);
            end
          end
        end
      end
      B_UNIT: begin
        if (ustat.done) begin
          if (!ustat.ok) begin
            deg <= 1'b1;
          end else begin
            case (vsel)
              2'd0: begin
                for (int i = 0; i < 3; i++) tu[i] <= $signed(uvec[i]);
                vsel <= 2'd1;
              end
              2'd1: begin
                for (int i = 0; i < 3; i++) bu[i] <= $signed(uvec[i]);
                pair <= 4'd7;
                mcyc <= 2'd0;
              end
              default: begin
                for (int i = 0; i < 3; i++) nu[i] <= $signed(uvec[i]);
              end
            endcase
          end
        end
      end
      B_OUT: begin
        if (load_out) begin
          m_tuser <= deg;
          if (deg) m_tdata <= '0;
          else     m_tdata <= {nu[2], nu[1], nu[0], bu[2], bu[1], bu[0], tu[2], tu[1], tu[0]};
        end
      end
      default: ;
    endcase
  end

  `TFT_ASSERT(a_pop_idle, clk, rst, pop |-> (state == B_IDLE), "queue popped outside idle")
  `TFT_ASSERT(a_load_free, clk, rst, load_out |-> (!m_tvalid || m_tready), "result overwritten")
  `TFT_ASSERT(a_deg_zero, clk, rst, (m_tvalid && m_tuser) |-> (m_tdata == '0), "degenerate not zero")
  `TFT_ASSERT(a_done_unit, clk, rst, ustat.done |-> (state == B_UNIT), "normaliser done unexpectedly")
  `TFT_ASSERT_NORST(a_rst_clear, clk, $past(rst) |-> !m_tvalid, "result valid after reset")

endmodule

// ----- design/triangle_tangent_frame_core.sv -----
// Top level of the triangle tangent frame core.
// Depends on tft_pkg, tft_front, tft_fifo and tft_back.
//
//  channel | dir | fields (tdata / tuser, lowest bits first)
//  s_*     | in  | tdata: pos_x, pos_y, pos_z, tex_u, tex_v (32 each)
//  m_*     | out | tdata: tangent, binormal, normal x/y/z (16 each); tuser: degenerate
//
// Every third vertex closes a triangle and queues it, waiting while the queue is full.
// The back end takes one triangle at a time and, besides the shared multiplier, spends
// most of its time in the normaliser: three passes of a one-bit-a-cycle square root
// and a one-bit-a-cycle divider per component.
// The two-entry queue and the output register let either side stall on its own.
// Reset is synchronous and clears the phase counter, queue and handshake state.
module triangle_tangent_frame_core #(
  parameter int COORD_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [159:0]  s_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [143:0]  m_tdata,   // tangent x,y,z, binormal x,y,z, normal x,y,z
  output logic          m_tuser    // degenerate
);
  import tft_pkg::*;

  tri_t push_data;
  tri_t pop_data;
  logic push, full, pop, empty;

  tft_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  tft_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  tft_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_data (pop_data),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- bench/tb_triangle_tangent_frame_core.sv -----
// Testbench for triangle_tangent_frame_core: vertex stream in, one tangent frame per triangle out.
// Depends on tft_pkg and the core RTL; the expected frames come from a fixed-point predictor below.
`timescale 1ns / 1ps
module tb_triangle_tangent_frame_core;
  import tft_pkg::*;

  localparam int LIMIT_CYCLES = 1500000;
  localparam int DRAIN_CYCLES = 800;

  typedef struct packed {
    logic [2:0][15:0] nrm;
    logic [2:0][15:0] bin;
    logic [2:0][15:0] tan;
  } frame_vec_t;

  typedef struct {
    frame_vec_t vec;
    logic       degenerate;
  } frame_t;

  logic         clk, rst;
  logic         s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
  logic [159:0] s_tdata;
  logic [143:0] m_tdata;

  triangle_tangent_frame_core #(.COORD_WIDTH(32)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  frame_t expected_frames[$];
  int     errors = 0;
  int     cycle_count = 0;
  bit     sink_idle_en = 0;
  bit     src_idle_en = 0;
  int     sink_hold = 0;

  // predictor state
  logic [1:0]         phase_q;
  longint             p1[3], p2[3], t1[2], t2[2];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t timeout", $time);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic longint mag(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // share one truncating shift so every magnitude sits below 2^30
  task automatic block_scale(ref longint v[], input int n);
    longint m;
    int     s;
    m = 0;
    s = 0;
    for (int i = 0; i < n; i++) if (mag(v[i]) > m) m = mag(v[i]);
    while (m >= (64'sd1 <<< 30)) begin
      m = m >>> 1;
      s++;
    end
    for (int i = 0; i < n; i++) v[i] = v[i] < 0 ? -(mag(v[i]) >>> s) : (mag(v[i]) >>> s);
  endtask

  function automatic bit to_unit(input longint v[3], output longint u[3]);
    longint mg[3], m, sum, len, q;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = mag(v[i]);
      if (mg[i] > m) m = mg[i];
      u[i] = 0;
    end
    if (m == 0) return 0;
    while (m >= (64'sd1 <<< 30)) begin
      m = m >>> 1;
      for (int i = 0; i < 3; i++) mg[i] = mg[i] >>> 1;
    end
    while (m < (64'sd1 <<< 29)) begin
      m = m <<< 1;
      for (int i = 0; i < 3; i++) mg[i] = mg[i] <<< 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) sum += mg[i] * mg[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (mg[i] * 32768 + len) / (2 * len);
      if (q > 16384) q = 16384;
      u[i] = v[i] < 0 ? -q : q;
    end
    return 1;
  endfunction

  // advance the predictor by one vertex and queue a frame when a triangle closes
  task automatic predict_vertex(input logic [159:0] vtx);
    longint p[3], t[2], tu[3], bu[3], nu[3], tv[3], bv[3], nv[3], det;
    longint e[], d[];
    bit     deg;
    frame_t fr;
    for (int i = 0; i < 3; i++) p[i] = longint'($signed(vtx[32*i +: 32]));
    for (int i = 0; i < 2; i++) t[i] = longint'($signed(vtx[96 + 32*i +: 32]));
    if (phase_q != 2'd1 && phase_q != 2'd2) begin
      p1 = p;
      t1 = t;
      phase_q = 2'd1;
      return;
    end
    if (phase_q == 2'd1) begin
      p2 = p;
      t2 = t;
      phase_q = 2'd2;
      return;
    end
    phase_q = 2'd0;
    e = new[6];
    d = new[4];
    for (int i = 0; i < 3; i++) begin
      e[i] = p2[i] - p1[i];
      e[3+i] = p[i] - p1[i];
    end
    d[0] = t2[0] - t1[0];
    d[1] = t[0] - t1[0];
    d[2] = t2[1] - t1[1];
    d[3] = t[1] - t1[1];
    block_scale(e, 6);
    block_scale(d, 4);
    deg = 0;
    tu = '{0, 0, 0};
    bu = '{0, 0, 0};
    nu = '{0, 0, 0};
    det = d[0] * d[3] - d[1] * d[2];
    if (det == 0) begin
      deg = 1;
    end else begin
      for (int i = 0; i < 3; i++) begin
        tv[i] = d[3] * e[i] - d[2] * e[3+i];
        bv[i] = d[0] * e[3+i] - d[1] * e[i];
        if (det < 0) begin
          tv[i] = -tv[i];
          bv[i] = -bv[i];
        end
      end
      if (!to_unit(tv, tu) || !to_unit(bv, bu)) begin
        deg = 1;
      end else begin
        nv[0] = tu[1] * bu[2] - tu[2] * bu[1];
        nv[1] = tu[2] * bu[0] - tu[0] * bu[2];
        nv[2] = tu[0] * bu[1] - tu[1] * bu[0];
        if (!to_unit(nv, nu)) deg = 1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      fr.vec.tan[i] = deg ? 16'd0 : tu[i][15:0];
      fr.vec.bin[i] = deg ? 16'd0 : bu[i][15:0];
      fr.vec.nrm[i] = deg ? 16'd0 : nu[i][15:0];
    end
    fr.degenerate = deg;
    expected_frames.insert(expected_frames.size(), fr);
  endtask

  // sink side: random stalls, plus a counted long hold when requested
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= sink_idle_en ? ($urandom_range(99) >= 18) : 1'b1;
    end
  end

  always @(posedge clk) begin
    frame_t     exp_fr;
    frame_vec_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_frames.size() == 0) begin
        $display("%0t unexpected frame %h deg %b", $time, m_tdata, m_tuser);
        errors++;
      end else begin
        exp_fr = expected_frames.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got.tan[i] !== exp_fr.vec.tan[i])
            $display("%0t tangent[%0d] exp %h got %h", $time, i, exp_fr.vec.tan[i], got.tan[i]);
          if (got.bin[i] !== exp_fr.vec.bin[i])
            $display("%0t binormal[%0d] exp %h got %h", $time, i, exp_fr.vec.bin[i], got.bin[i]);
          if (got.nrm[i] !== exp_fr.vec.nrm[i])
            $display("%0t normal[%0d] exp %h got %h", $time, i, exp_fr.vec.nrm[i], got.nrm[i]);
        end
        if (m_tuser !== exp_fr.degenerate)
          $display("%0t degenerate exp %b got %b", $time, exp_fr.degenerate, m_tuser);
        if (got !== exp_fr.vec || m_tuser !== exp_fr.degenerate) errors++;
      end
    end
  end

  // entered at a falling edge; holds the request until it is taken
  task automatic send_vertex(input logic [159:0] vtx);
    if (src_idle_en) begin
      while ($urandom_range(99) < 18) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_tdata  <= vtx;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_vertex(vtx);
    @(negedge clk);
  endtask

  function automatic logic [159:0] pack_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                              logic [31:0] u, logic [31:0] v);
    return {v, u, z, y, x};
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0:       return $urandom();
      1:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(8000000)) - 4000000);
    endcase
  endfunction

  task automatic send_triangle(input bit degenerate_uv);
    logic [31:0] u, v;
    u = rand_coord();
    v = rand_coord();
    for (int k = 0; k < 3; k++)
      send_vertex(pack_vertex(rand_coord(), rand_coord(), rand_coord(),
                              degenerate_uv ? u : rand_coord(),
                              degenerate_uv ? v : rand_coord()));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_frames.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    logic [31:0] one;
    one = 32'h0001_0000;
    // unit right triangle with matching texture axes
    send_vertex(pack_vertex(0, 0, 0, 0, 0));
    send_vertex(pack_vertex(one, 0, 0, one, 0));
    send_vertex(pack_vertex(0, one, 0, 0, one));
    // mirrored texture: negative determinant
    send_vertex(pack_vertex(0, 0, 0, 0, 0));
    send_vertex(pack_vertex(one, 0, 0, 0, one));
    send_vertex(pack_vertex(0, one, 0, one, 0));
    // zero determinant
    send_vertex(pack_vertex(0, 0, 0, one, one));
    send_vertex(pack_vertex(one, 0, 0, one, one));
    send_vertex(pack_vertex(0, 0, one, one, one));
    // collapsed positions: zero tangent and binormal
    send_vertex(pack_vertex(one, one, one, 0, 0));
    send_vertex(pack_vertex(one, one, one, one, 0));
    send_vertex(pack_vertex(one, one, one, 0, one));
    // collinear edges: tangent parallel to binormal
    send_vertex(pack_vertex(0, 0, 0, 0, 0));
    send_vertex(pack_vertex(one, 0, 0, one, 0));
    send_vertex(pack_vertex(2 * one, 0, 0, 0, one));
    // extreme coordinates: large deltas need block scaling
    send_vertex(pack_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    send_vertex(pack_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff));
    send_vertex(pack_vertex(32'h0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
    // tiny deltas: left-shift path of the normaliser
    send_vertex(pack_vertex(32'hffff_ffff, 0, 1, 0, 0));
    send_vertex(pack_vertex(1, 0, 0, 1, 0));
    send_vertex(pack_vertex(0, 1, 0, 0, 1));
    wait_drained();
  endtask

  task automatic test_random_stream();
    src_idle_en  = 1;
    sink_idle_en = 1;
    for (int n = 0; n < 380; n++) send_triangle($urandom_range(9) == 0);
    wait_drained();
  endtask

  task automatic test_sink_backpressure();
    src_idle_en  = 0;
    sink_idle_en = 0;
    sink_hold    = 3000;
    for (int n = 0; n < 12; n++) send_triangle(0);
    wait_drained();
  endtask

  task automatic test_full_rate();
    src_idle_en  = 0;
    sink_idle_en = 0;
    for (int n = 0; n < 40; n++) send_triangle(0);
    wait_drained();
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    phase_q  = 2'd0;
    p1 = '{0, 0, 0};
    p2 = '{0, 0, 0};
    t1 = '{0, 0};
    t2 = '{0, 0};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_full_rate();
    test_sink_backpressure();
    test_random_stream();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
